### rtl/core/cbm_pkg.sv
// Shared constants and types of the cartridge bank mapper.
// Used by every module below rtl/core; it depends on nothing else.
package cbm_pkg;

  localparam int RAM_BYTES_MAX = 32768;
  localparam int ROM_BANKS_MAX = 512;
  localparam int RAM_AW        = $clog2(RAM_BYTES_MAX);
  localparam int WIN_AW        = 13;
  localparam int RAM_BANK_W    = RAM_AW - WIN_AW;
  localparam int BANK_W        = $clog2(ROM_BANKS_MAX);
  localparam int CNT_W         = 10;
  localparam int STEP_W        = $clog2(BANK_W + 1);

  localparam logic [CNT_W-1:0] ROM_BANKS_CAP = CNT_W'(ROM_BANKS_MAX);
  localparam logic [15:0]      RAM_BANKED    = 16'(RAM_BYTES_MAX);

  localparam logic       CFG_ROM_BANK_COUNT = 1'b0;
  localparam logic       CFG_RAM_BYTES      = 1'b1;
  localparam logic       ACC_WRITE          = 1'b1;

  localparam logic [7:0] MODE_RAM_DATA = 8'h0A;
  localparam logic [7:0] MODE_ONE_A    = 8'h0C;
  localparam logic [7:0] MODE_ONE_B    = 8'h0D;
  localparam logic [7:0] BYTE_ONE      = 8'h01;
  localparam logic [7:0] BYTE_OPEN     = 8'hFF;

  typedef struct packed {
    logic load;
    logic exec;
    logic mod_start;
    logic mod_step;
  } cbm_cmd_t;

  typedef struct packed {
    logic bank_write;
    logic mod_done;
  } cbm_status_t;

endpackage

### rtl/core/cbm_remu.sv
// Iterative remainder unit: one dividend bit per cycle while step is high, restoring form.
// Depends on cbm_pkg for the bank and count widths.
module cbm_remu (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       step,
  input  logic [cbm_pkg::BANK_W-1:0] dividend,
  input  logic [cbm_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [cbm_pkg::BANK_W-1:0] remainder
);
  import cbm_pkg::*;

  logic [BANK_W-1:0] dvd_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic [CNT_W-1:0]  shifted;
  logic [CNT_W-1:0]  rem_nxt;

  assign shifted   = {rem_r[CNT_W-2:0], dvd_r[BANK_W-1]};
  assign rem_nxt   = (shifted >= dsr_r) ? (shifted - dsr_r) : shifted;
  assign done      = step && (cnt_r == STEP_W'(1));
  assign remainder = rem_nxt[BANK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= STEP_W'(BANK_W);
    end else if (step && cnt_r != '0) begin
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (step && cnt_r != '0) begin
      dvd_r <= {dvd_r[BANK_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

endmodule

### rtl/core/cbm_dpath.sv
// Datapath: access registers, bank registers, cartridge RAM and decode.
// Depends on cbm_pkg and cbm_remu.
module cbm_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbm_pkg::cbm_cmd_t             cmd,
  output cbm_pkg::cbm_status_t          status,
  input  logic                          cfg_wr,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_mode,
  input  logic [15:0]                   in_bus_address,
  input  logic [7:0]                    in_write_byte,
  output logic                          out_claimed,
  output logic                          out_rom_fetch,
  output logic [22:0]                   out_rom_byte_address,
  output logic [7:0]                    out_read_byte
);
  import cbm_pkg::*;

  logic [CNT_W-1:0]      bank_count_r;
  logic [15:0]           ram_bytes_r;
  logic [7:0]            ram_mode_r;
  logic [7:0]            rom_low_r;
  logic                  rom_high_r;
  logic [BANK_W-1:0]     active_bank_r;
  logic [RAM_BANK_W-1:0] ram_bank_r;
  logic                  wr_r;
  logic [15:0]           addr_r;
  logic [7:0]            data_r;
  logic [7:0]            ram_q_r;
  logic [7:0]            cart_ram [RAM_BYTES_MAX];

  logic              rom_range;
  logic              ram_range;
  logic              sel_mode;
  logic              sel_low;
  logic              sel_high;
  logic              sel_ram_bank;
  logic [5:0]        win_pages;
  logic              in_window;
  logic [7:0]        rom_low_nxt;
  logic              rom_high_nxt;
  logic [CNT_W-1:0]  divisor;
  logic              mod_done;
  logic [BANK_W-1:0] mod_rem;

  assign rom_range    = !addr_r[15];
  assign ram_range    = (addr_r[15:13] == 3'b101);
  assign sel_mode     = rom_range && (addr_r[14:13] == 2'b00);
  assign sel_low      = (addr_r[15:8] == 8'h20);
  assign sel_high     = (addr_r[15:12] == 4'h3);
  assign sel_ram_bank = (addr_r[15:8] == 8'h40);
  assign win_pages    = (ram_bytes_r > 16'd8192) ? 6'd32 : ram_bytes_r[13:8];
  assign in_window    = ({1'b0, addr_r[12:8]} < win_pages);
  assign rom_low_nxt  = sel_low ? data_r : rom_low_r;
  assign rom_high_nxt = sel_high ? data_r[0] : rom_high_r;
  assign divisor      = (bank_count_r > ROM_BANKS_CAP) ? ROM_BANKS_CAP : bank_count_r;

  assign status.bank_write = (wr_r == ACC_WRITE) && (sel_low || sel_high);
  assign status.mod_done   = mod_done;

  cbm_remu u_remu (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (cmd.mod_start),
    .step      (cmd.mod_step),
    .dividend  ({rom_high_nxt, rom_low_nxt}),
    .divisor   (divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    out_claimed          = rom_range || ram_range;
    out_rom_fetch        = rom_range && (wr_r != ACC_WRITE);
    out_rom_byte_address = '0;
    out_read_byte        = '0;
    if (out_rom_fetch) begin
      if (!addr_r[14]) begin
        out_rom_byte_address = {7'd0, addr_r};
      end else begin
        out_rom_byte_address = {active_bank_r, addr_r[13:0]};
      end
    end
    if (ram_range && wr_r != ACC_WRITE) begin
      if (!in_window) begin
        out_read_byte = BYTE_OPEN;
      end else if (ram_mode_r == MODE_RAM_DATA) begin
        out_read_byte = ram_q_r;
      end else if (ram_mode_r == MODE_ONE_A || ram_mode_r == MODE_ONE_B) begin
        out_read_byte = BYTE_ONE;
      end else begin
        out_read_byte = BYTE_OPEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_count_r  <= CNT_W'(2);
      ram_bytes_r   <= '0;
      ram_mode_r    <= '0;
      rom_low_r     <= 8'd1;
      rom_high_r    <= 1'b0;
      active_bank_r <= BANK_W'(1);
      ram_bank_r    <= '0;
    end else begin
      if (cfg_wr && cfg_index == CFG_ROM_BANK_COUNT) begin
        bank_count_r <= cfg_data[CNT_W-1:0];
      end
      if (cfg_wr && cfg_index == CFG_RAM_BYTES) begin
        ram_bytes_r <= cfg_data;
      end
      if (cmd.exec && wr_r == ACC_WRITE && rom_range) begin
        if (sel_mode) begin
          ram_mode_r <= data_r;
        end
        rom_low_r  <= rom_low_nxt;
        rom_high_r <= rom_high_nxt;
        if (sel_ram_bank && ram_bytes_r == RAM_BANKED) begin
          ram_bank_r <= data_r[RAM_BANK_W-1:0];
        end
      end
      if (mod_done) begin
        active_bank_r <= (mod_rem == '0) ? BANK_W'(1) : mod_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wr_r   <= in_mode;
      addr_r <= in_bus_address;
      data_r <= in_write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ram_q_r <= cart_ram[{ram_bank_r, in_bus_address[WIN_AW-1:0]}];
    end
    if (cmd.exec && wr_r == ACC_WRITE && ram_range && in_window) begin
      cart_ram[{ram_bank_r, addr_r[WIN_AW-1:0]}] <= data_r;
    end
  end

endmodule

### rtl/core/cbm_ctrl.sv
// Controller: sequences accept, execute and the bank remainder steps.
// Depends on cbm_pkg for the command and status types.
module cbm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  cbm_pkg::cbm_status_t status,
  output cbm_pkg::cbm_cmd_t    cmd,
  output logic                 busy
);
  import cbm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  assign busy = busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.bank_write) begin
          cmd.mod_start = 1'b1;
          state_nxt     = ST_MOD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

endmodule

### rtl/core/cartridge_bank_mapper_core.sv
// Top level of the cartridge bank mapper: the controller and the datapath.
// An accepted access shows its result beat with out_valid in the next cycle.
// Every access is accepted and then executed; a ROM bank register write then also
// steps the remainder unit, which resolves one bank bit per cycle.
// Synchronous active-low reset; cartridge RAM contents are not cleared.
// Depends on cbm_pkg, cbm_ctrl, cbm_dpath and cbm_remu.
module cartridge_bank_mapper_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  output logic        out_claimed,
  output logic        out_rom_fetch,
  output logic [22:0] out_rom_byte_address,
  output logic [7:0]  out_read_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import cbm_pkg::*;

  cbm_cmd_t    cmd;
  cbm_status_t status;

  assign cfg_ready = 1'b1;
  assign out_valid = cmd.exec;

  cbm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  cbm_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .cfg_wr               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_mode              (in_mode),
    .in_bus_address       (in_bus_address),
    .in_write_byte        (in_write_byte),
    .out_claimed          (out_claimed),
    .out_rom_fetch        (out_rom_fetch),
    .out_rom_byte_address (out_rom_byte_address),
    .out_read_byte        (out_read_byte)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("result beat missing after accepted access");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat repeated");

  a_beat_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat outside an access");

  a_fetch_claimed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rom_fetch |-> out_claimed && out_read_byte == 8'h00)
    else $error("ROM fetch on an unclaimed access");
`endif

endmodule
